FILE: rtl/fcdt_pkg.sv
// ============================================================================
// fcdt_pkg
// Shared types and codes for the flow counter delta table and its cells.
// ============================================================================
package fcdt_pkg;

   // default table depth
   localparam int TableEntriesDefault = 256;

   // item kinds carried on the request tuser bit
   localparam logic OP_SYNC = 1'b0;
   localparam logic OP_READ = 1'b1;

   // response status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // request and response tdata widths, padded to whole bytes
   localparam int ReqDataW = 200;
   localparam int RspDataW = 72;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic        commit;   // apply the update this cycle
      logic        op;       // OP_SYNC or OP_READ
      logic        remove;   // sync: delete on hit
      logic        any_hit;  // some cell matched the key
      logic [63:0] key;
      logic [63:0] total;    // sync: forward plus optional reverse count
   } cmd_type;

   // search results handed from cell to cell
   typedef struct packed {
      logic        hit;      // a matching entry lies at or below this cell
      logic        free;     // a free entry lies at or below this cell
      logic [63:0] delta;    // newest minus snapshot of the matching entry
   } link_type;

endpackage

FILE: rtl/fcdt_cell.sv
// ============================================================================
// fcdt_cell
// One table entry. Compares its key with the broadcast command, forwards the
// hit, free and delta results to the next cell, and applies the update when
// the controller commits.
// ============================================================================
module fcdt_cell (
   input  logic               clock,
   input  logic               reset,
   input  fcdt_pkg::cmd_type  cmd_in,
   input  fcdt_pkg::link_type link_in,
   output fcdt_pkg::link_type link_out
);
   import fcdt_pkg::*;

   logic        valid_ff, valid_in;
   logic [63:0] key_ff, key_in;
   logic [63:0] newest_ff, newest_in;
   logic [63:0] snapshot_ff, snapshot_in;
   link_type    link_ff, link_in_next;

   logic match;
   logic hit_first;
   logic free_first;

   // this cell is the lowest matching or lowest free entry
   assign match      = valid_ff && (key_ff == cmd_in.key);
   assign hit_first  = match && !link_in.hit;
   assign free_first = !valid_ff && !link_in.free;

   // results handed on to the next cell
   always_comb begin
      link_in_next.hit   = link_in.hit | match;
      link_in_next.free  = link_in.free | !valid_ff;
      link_in_next.delta = hit_first ? (newest_ff - snapshot_ff) : link_in.delta;
   end

   // entry update on commit
   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      newest_in   = newest_ff;
      snapshot_in = snapshot_ff;
      if (cmd_in.commit) begin
         if (cmd_in.op == OP_READ) begin
            if (hit_first) begin
               snapshot_in = newest_ff;
            end
         end else if (hit_first) begin
            if (cmd_in.remove) begin
               valid_in = 1'b0;
            end else if (snapshot_ff != cmd_in.total) begin
               newest_in = cmd_in.total;
            end
         end else if (!cmd_in.any_hit && !cmd_in.remove && free_first) begin
            valid_in    = 1'b1;
            key_in      = cmd_in.key;
            newest_in   = cmd_in.total;
            snapshot_in = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      newest_ff   <= newest_in;
      snapshot_ff <= snapshot_in;
      link_ff     <= link_in_next;
   end

   assign link_out = link_ff;

endmodule

FILE: rtl/flow_counter_delta_table.sv
// ============================================================================
// flow_counter_delta_table
// Flow counter table keyed by a 64-bit flow key, built as a row of cells.
// ============================================================================
// Usage:
//   The req channel takes one item per transfer: tuser selects sync or read,
//   tdata carries the key, remove and one-way flags and the packet counts.
//   The rsp channel returns exactly one result per item: status, found and
//   the packet delta (nonzero only for a read that hits).
//   Each cell holds one entry; the search result travels down the row one
//   cell per cycle, so an item passes through the search state and then the
//   commit state, which also loads the response register. One item is in
//   flight at a time; a new request is taken in the cycle after the
//   response transfer. The row length sets how long the search takes.
//   Reset clears every entry valid bit at once, so the table starts empty
//   and the first request can be taken in the cycle after reset.
//   When the receiver stalls, the response holds in its register and no new
//   request is taken until it has been transferred.
// ============================================================================
module flow_counter_delta_table #(
   parameter int TABLE_ENTRIES = fcdt_pkg::TableEntriesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: flow_key[63:0], remove[64], one_way[65], fwd_pkts[129:66],
   //        rev_pkts[193:130], zero pad
   input  logic [fcdt_pkg::ReqDataW-1:0]  req_tdata,
   // tuser: op[0]
   input  logic                           req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: status[0], found[1], pkts_delta[65:2], zero pad
   output logic [fcdt_pkg::RspDataW-1:0]  rsp_tdata
);
   import fcdt_pkg::*;

   localparam int CntW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT,
      ST_RESP
   } state_type;

   state_type     state_ff;
   logic [CntW-1:0] count_ff;
   logic          rsp_valid_ff;
   logic          rsp_status_ff;
   logic          rsp_found_ff;
   logic [63:0]   rsp_delta_ff;

   logic          q_op_ff;
   logic          q_remove_ff;
   logic [63:0]   q_key_ff;
   logic [63:0]   q_total_ff;

   logic          req_xfer;
   logic          rsp_xfer;
   logic [63:0]   req_key;
   logic          req_remove;
   logic          req_one_way;
   logic [63:0]   req_fwd;
   logic [63:0]   req_rev;
   logic [63:0]   req_total;

   cmd_type       cmd;
   link_type      links [0:TABLE_ENTRIES];
   link_type      tail;

   // request field unpack
   assign req_key     = req_tdata[63:0];
   assign req_remove  = req_tdata[64];
   assign req_one_way = req_tdata[65];
   assign req_fwd     = req_tdata[129:66];
   assign req_rev     = req_tdata[193:130];
   assign req_total   = req_one_way ? req_fwd : (req_fwd + req_rev);

   // no request is taken while reset is held
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;

   // command broadcast to the row
   assign tail = links[TABLE_ENTRIES];
   always_comb begin
      cmd.commit  = (state_ff == ST_COMMIT);
      cmd.op      = q_op_ff;
      cmd.remove  = q_remove_ff;
      cmd.any_hit = tail.hit;
      cmd.key     = q_key_ff;
      cmd.total   = q_total_ff;
   end

   // row of entry cells
   assign links[0] = '0;
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      fcdt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd_in   (cmd),
         .link_in  (links[i]),
         .link_out (links[i+1])
      );
   end

   // sequencer with response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               count_ff <= '0;
               if (req_xfer) begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == CntW'(TABLE_ENTRIES - 1)) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               state_ff      <= ST_RESP;
               rsp_valid_ff  <= 1'b1;
               rsp_found_ff  <= tail.hit;
               rsp_status_ff <= (q_op_ff == OP_SYNC && !tail.hit && !q_remove_ff
                                 && !tail.free) ? STATUS_FULL : STATUS_DONE;
               rsp_delta_ff  <= (q_op_ff == OP_READ) ? tail.delta : 64'd0;
            end
            ST_RESP: begin
               if (rsp_xfer) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // captured request
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         q_op_ff     <= req_tuser;
         q_remove_ff <= req_remove;
         q_key_ff    <= req_key;
         q_total_ff  <= req_total;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - 66){1'b0}}, rsp_delta_ff, rsp_found_ff, rsp_status_ff};

`ifndef SYNTHESIS
   // one item in flight: no request right after a transfer
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request taken while an item is in flight");

   // response is valid once the search and commit states are through
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> ##(TABLE_ENTRIES + 2) rsp_tvalid)
      else $error("response not ready after the search");

   // table full only on a miss
   a_full_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_status_ff == STATUS_FULL && rsp_found_ff))
      else $error("table full reported on a hit");

   // a delta only comes from a matching entry
   a_delta_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_delta_ff != 64'd0) |-> rsp_found_ff)
      else $error("delta returned without a match");
`endif

endmodule
